// ----- src/segmented_table_interpolator_core_assert.svh -----
// Assertion macros used by the back end of the segmented table interpolator RTL.
`ifndef SEGMENTED_TABLE_INTERPOLATOR_CORE_ASSERT_SVH
`define SEGMENTED_TABLE_INTERPOLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define STIC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define STIC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define STIC_ASSERT_IMP(label, clk, rst, ante, cons)
`define STIC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- src/stic_pkg.sv -----
// Types and constants of the segmented table interpolator.
`timescale 1ns / 1ps
package stic_pkg;
   localparam int COLUMNS    = 331;
   localparam int LAST_COL   = COLUMNS - 1;
   localparam int PEAK_SEL   = COLUMNS;
   localparam int ROW_STRIDE = COLUMNS + 1;
   localparam logic [8:0] PEAK_RESET = 9'd289;
   localparam logic signed [63:0] Q_ONE   = 64'sh0000_0001_0000_0000;
   localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

   typedef enum logic [1:0] {CMD_LOAD, CMD_INTERP, CMD_SLOPE, CMD_INVERSE} cmd_type;
   typedef enum logic [1:0] {ST_OK, ST_CLAMPED, ST_NO_CONVERGE} status_type;

   typedef struct packed {
      logic [1:0]          command;
      logic [2:0]          row;
      logic [8:0]          column;
      logic [41:0]         temperature;
      logic signed [63:0]  pressure;
      logic signed [63:0]  data_value;
   } req_type;

   typedef struct packed {
      logic signed [63:0]  result_value;
      logic [8:0]          cell_column;
      logic [1:0]          status;
   } rsp_type;

   typedef struct packed {
      req_type     req;
      logic [8:0]  seg_col;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic               start;
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] c;
   } md_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] quotient;
   } md_rsp_type;

   typedef enum logic [3:0] {
      B_IDLE, B_DISPATCH, B_FETCH, B_DRAIN, B_SELECT, B_LOOP, B_CHECK, B_HIT,
      B_TAIL, B_PREP, B_START, B_DIVIDE, B_OUT
   } back_state_type;

   typedef enum logic [2:0] {MD_IDLE, MD_MUL, MD_CHECK, MD_DIV, MD_DONE} md_state_type;
endpackage

// ----- src/stic_front.sv -----
// Front end: takes requests and maps temperature to its segment column.
`timescale 1ns / 1ps
module stic_front import stic_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_payload,
   output logic             push,
   output entry_type        push_entry,
   input  queue_status_type q_status
);
   localparam logic [9:0] SEG_TOP [12] = '{10'd250, 10'd350, 10'd360, 10'd370, 10'd372,
      10'd378, 10'd380, 10'd390, 10'd400, 10'd450, 10'd550, 10'd1000};
   localparam logic [9:0] SEG_BASE [12] = '{10'd0, 10'd250, 10'd350, 10'd360, 10'd370,
      10'd372, 10'd378, 10'd380, 10'd390, 10'd400, 10'd450, 10'd550};
   localparam logic [8:0] SEG_OFF [12] = '{9'd0, 9'd50, 9'd100, 9'd110, 9'd130, 9'd140,
      9'd200, 9'd210, 9'd230, 9'd240, 9'd265, 9'd285};
   localparam logic [3:0] SEG_NUM [12] = '{4'd5, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
      4'd1, 4'd2, 4'd5, 4'd10};
   localparam logic [3:0] SEG_DEN [12] = '{4'd1, 4'd1, 4'd1, 4'd2, 4'd5, 4'd10, 4'd5, 4'd2,
      4'd1, 4'd1, 4'd1, 4'd1};

   function automatic logic [8:0] column_of(input logic [41:0] t);
      logic [8:0]  idx;
      logic [41:0] diff;
      logic [45:0] scaled;
      logic [13:0] ip;
      logic [13:0] q;
      logic [14:0] sum;
      idx = 9'(LAST_COL);
      // lowest matching segment wins
      for (int k = 11; k >= 0; k--) begin
         if (t <= {SEG_TOP[k], 32'd0}) begin
            diff   = t - {SEG_BASE[k], 32'd0};
            scaled = 46'(diff) * 46'(SEG_DEN[k]);
            ip     = scaled[45:32];
            // ip stays below 1024 inside its segment, where *205 >> 10 equals /5
            case (SEG_NUM[k])
               4'd2:    q = ip >> 1;
               4'd5:    q = 14'((22'(ip) * 22'd205) >> 10);
               4'd10:   q = 14'((22'(ip) * 22'd205) >> 11);
               default: q = ip;
            endcase
            sum = 15'(SEG_OFF[k]) + 15'(q);
            idx = (sum > 15'(LAST_COL)) ? 9'(LAST_COL) : sum[8:0];
         end
      end
      return idx;
   endfunction

   logic    hold_valid_ff, hold_valid_in;
   req_type hold_ff;

   assign push      = hold_valid_ff && !q_status.full;
   assign req_ready = !hold_valid_ff || !q_status.full;

   always_comb begin
      if (req_valid && req_ready) hold_valid_in = 1'b1;
      else if (push)              hold_valid_in = 1'b0;
      else                        hold_valid_in = hold_valid_ff;
      push_entry.req     = hold_ff;
      push_entry.seg_col = column_of(hold_ff.temperature);
   end

   always_ff @(posedge clock) begin
      if (reset) hold_valid_ff <= 1'b0;
      else       hold_valid_ff <= hold_valid_in;
      if (req_valid && req_ready) hold_ff <= req_payload;
   end
endmodule

// ----- src/stic_queue.sv -----
// Two-entry queue between front end and back end.
`timescale 1ns / 1ps
module stic_queue import stic_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        pop_entry,
   output queue_status_type q_status
);
   entry_type  ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
      q_status.full  = (count_ff == 2'd2);
      q_status.empty = (count_ff == 2'd0);
      pop_entry = ent_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) ent_ff[wr_ptr_ff] <= push_entry;
   end
endmodule

// ----- src/stic_muldiv.sv -----
// Iterative a*b/c unit: four 32x32 partial products, then 64 restoring steps unless the quotient overflows.
`timescale 1ns / 1ps
module stic_muldiv import stic_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  md_req_type md_req,
   output md_rsp_type md_rsp
);
   function automatic logic [63:0] mag(input logic signed [63:0] x);
      return x[63] ? (64'd0 - 64'(x)) : 64'(x);
   endfunction

   function automatic logic signed [63:0] finish(input logic [63:0] q, input logic neg);
      logic signed [63:0] r;
      if (neg) r = (q > 64'h8000_0000_0000_0000) ? VAL_MIN : $signed(64'd0 - q);
      else     r = q[63] ? VAL_MAX : $signed(q);
      return r;
   endfunction

   md_state_type       state_ff, state_in;
   logic [63:0]        ua_ff, ua_in, ub_ff, ub_in, uc_ff, uc_in, q_ff, q_in;
   logic               neg_ff, neg_in;
   logic [127:0]       acc_ff, acc_in;
   logic [5:0]         step_ff, step_in;
   logic signed [63:0] res_ff, res_in;
   logic [31:0]        opa, opb;
   logic [63:0]        prod, r1;
   logic               ge;

   always_comb begin
      state_in = state_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      uc_in    = uc_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      step_in  = step_ff;
      q_in     = q_ff;
      res_in   = res_ff;
      opa  = step_ff[1] ? ua_ff[63:32] : ua_ff[31:0];
      opb  = step_ff[0] ? ub_ff[63:32] : ub_ff[31:0];
      prod = 64'(opa) * 64'(opb);
      r1   = {acc_ff[126:64], acc_ff[63]};
      ge   = acc_ff[127] || (r1 >= uc_ff);
      md_rsp.done     = 1'b0;
      md_rsp.quotient = res_ff;
      case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               ua_in    = mag(md_req.a);
               ub_in    = mag(md_req.b);
               uc_in    = mag(md_req.c);
               neg_in   = md_req.a[63] ^ md_req.b[63] ^ md_req.c[63];
               acc_in   = '0;
               step_in  = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            acc_in  = acc_ff + (128'(prod) << (32 * (int'(step_ff[0]) + int'(step_ff[1]))));
            step_in = step_ff + 6'd1;
            if (step_ff[1:0] == 2'd3) state_in = MD_CHECK;
         end
         MD_CHECK: begin
            step_in = '0;
            q_in    = '0;
            if (acc_ff[127:64] >= uc_ff) begin
               res_in   = neg_ff ? VAL_MIN : VAL_MAX;
               state_in = MD_DONE;
            end else begin
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            acc_in  = {(ge ? (r1 - uc_ff) : r1), acc_ff[62:0], 1'b0};
            q_in    = {q_ff[62:0], ge};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd63) begin
               res_in   = finish(q_in, neg_ff);
               state_in = MD_DONE;
            end
         end
         MD_DONE: begin
            md_rsp.done = 1'b1;
            state_in    = MD_IDLE;
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= MD_IDLE;
      else       state_ff <= state_in;
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      uc_ff   <= uc_in;
      neg_ff  <= neg_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      q_ff    <= q_in;
      res_ff  <= res_in;
   end
endmodule

// ----- src/stic_back.sv -----
// Back end: table memory, lookup sequencer, inverse search and result register.
`timescale 1ns / 1ps
`include "segmented_table_interpolator_core_assert.svh"
module stic_back import stic_pkg::*; #(
   parameter int ROWS         = 8,
   parameter int SEARCH_LIMIT = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  entry_type        pop_entry,
   output logic             pop,
   input  logic [8:0]       peak_column,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_payload
);
   localparam int MEM_DEPTH = ROWS * ROW_STRIDE;
   localparam int AW        = $clog2(MEM_DEPTH);
   localparam int NW        = $clog2(SEARCH_LIMIT + 2);

   function automatic logic [AW-1:0] addr_of(input logic [2:0] r, input logic [8:0] c);
      return AW'(AW'(r) * AW'(ROW_STRIDE)) + AW'(c);
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] r;
      r = a - b;
      if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? VAL_MIN : VAL_MAX;
      return r;
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [63:0] r;
      r = a + b;
      if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? VAL_MIN : VAL_MAX;
      return r;
   endfunction

   logic signed [63:0] mem [MEM_DEPTH];

   back_state_type     state_ff, state_in;
   entry_type          item_ff, item_in;
   logic signed [63:0] v_ff [6];
   logic [2:0]         k_ff, k_in, rr_ff, rr_in;
   logic [8:0]         cc_ff, cc_in, cc1;
   logic               bracket_ff, bracket_in, rising_ff, rising_in, slope_ff, slope_in;
   logic [9:0]         hi_ff, hi_in, lo_ff, lo_in, g_ff, g_in;
   logic [NW-1:0]      n_ff, n_in;
   logic signed [63:0] x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic signed [63:0] xq_ff, xq_in, d_ff, d_in, na_ff, na_in, nb_ff, nb_in;
   logic signed [63:0] res_ff, res_in;
   logic [8:0]         cell_ff, cell_in;
   status_type         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               rd_en, rd_zero, rd_live, rd_zero_ff, rd_live_ff;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [2:0]         rd_slot, rd_slot_ff;
   logic signed [63:0] rd_data_ff, rd_value;
   logic               mem_we, rr_ok, cond;
   logic signed [63:0] tq, pq;
   md_req_type         md_req;
   md_rsp_type         md_rsp;

   stic_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   assign rd_value    = rd_zero_ff ? 64'sd0 : rd_data_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      k_in         = k_ff;
      rr_in        = rr_ff;
      cc_in        = cc_ff;
      bracket_in   = bracket_ff;
      rising_in    = rising_ff;
      slope_in     = slope_ff;
      hi_in        = hi_ff;
      lo_in        = lo_ff;
      g_in         = g_ff;
      n_in         = n_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y0_in        = y0_ff;
      y1_in        = y1_ff;
      xq_in        = xq_ff;
      d_in         = d_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      res_in       = res_ff;
      cell_in      = cell_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      wr_addr      = addr_of(item_ff.req.row, item_ff.req.column);
      rd_en        = 1'b0;
      rd_live      = 1'b0;
      rd_zero      = 1'b0;
      rd_slot      = k_ff;
      rd_addr      = addr_of(3'd1, g_ff[8:0]);
      md_req.start = 1'b0;
      md_req.a     = na_ff;
      md_req.b     = nb_ff;
      md_req.c     = d_ff;
      rr_ok        = int'(rr_ff) < ROWS;
      cc1          = (cc_ff == 9'(LAST_COL)) ? cc_ff : cc_ff + 9'd1;
      tq           = $signed({22'd0, item_ff.req.temperature});
      pq           = item_ff.req.pressure;
      cond         = rising_ff ? (pq < rd_value) : (pq > rd_value);

      case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               pop      = 1'b1;
               item_in  = pop_entry;
               state_in = B_DISPATCH;
            end
         end
         B_DISPATCH: begin
            res_in     = 64'sd0;
            cell_in    = 9'd0;
            status_in  = ST_OK;
            k_in       = 3'd0;
            bracket_in = 1'b0;
            case (item_ff.req.command)
               CMD_LOAD: begin
                  mem_we   = int'(item_ff.req.row) < ROWS && int'(item_ff.req.column) <= PEAK_SEL;
                  state_in = B_OUT;
               end
               CMD_INVERSE: begin
                  rr_in    = 3'd1;
                  cc_in    = peak_column;
                  state_in = B_FETCH;
               end
               default: begin
                  rr_in    = item_ff.req.row;
                  cc_in    = (item_ff.seg_col == 9'(LAST_COL)) ? 9'(LAST_COL - 1)
                                                              : item_ff.seg_col;
                  state_in = B_FETCH;
               end
            endcase
         end
         B_FETCH: begin
            // slots: peak row 0, peak row rr, row 0 at cc and cc+1, row rr at cc and cc+1
            rd_en   = 1'b1;
            rd_live = 1'b1;
            case (k_ff)
               3'd0: rd_addr = addr_of(3'd0, 9'(PEAK_SEL));
               3'd1: begin
                  rd_addr = addr_of(rr_ff, 9'(PEAK_SEL));
                  rd_zero = !rr_ok;
               end
               3'd2: rd_addr = addr_of(3'd0, cc_ff);
               3'd3: rd_addr = addr_of(3'd0, cc1);
               3'd4: begin
                  rd_addr = addr_of(rr_ff, cc_ff);
                  rd_zero = !rr_ok;
               end
               default: begin
                  rd_addr = addr_of(rr_ff, cc1);
                  rd_zero = !rr_ok;
               end
            endcase
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd5) state_in = B_DRAIN;
         end
         B_DRAIN: state_in = B_SELECT;
         B_SELECT: begin
            xq_in    = tq;
            slope_in = 1'b0;
            state_in = B_PREP;
            if (bracket_ff) begin
               x0_in   = v_ff[4];
               x1_in   = v_ff[5];
               y0_in   = v_ff[2];
               y1_in   = v_ff[3];
               xq_in   = pq;
               cell_in = cc_ff;
            end else if (item_ff.req.command == CMD_INVERSE) begin
               cell_in = peak_column;
               xq_in   = pq;
               if (pq == v_ff[1]) begin
                  res_in   = v_ff[0];
                  state_in = B_OUT;
               end else if (tq > v_ff[0] && pq >= v_ff[5]) begin
                  x0_in = v_ff[1];
                  x1_in = v_ff[5];
                  y0_in = v_ff[0];
                  y1_in = v_ff[3];
               end else if (tq < v_ff[0] && pq >= v_ff[4]) begin
                  x0_in = v_ff[4];
                  x1_in = v_ff[1];
                  y0_in = v_ff[2];
                  y1_in = v_ff[0];
               end else begin
                  rising_in = item_ff.seg_col < peak_column;
                  n_in      = '0;
                  if (item_ff.seg_col < peak_column) begin
                     hi_in = 10'(peak_column);
                     lo_in = 10'd0;
                     g_in  = 10'(peak_column) >> 1;
                  end else begin
                     hi_in = 10'(LAST_COL);
                     lo_in = 10'(peak_column) + 10'd1;
                     g_in  = (10'(peak_column) + 10'(LAST_COL)) >> 1;
                  end
                  state_in = B_LOOP;
               end
            end else begin
               slope_in = (item_ff.req.command == CMD_SLOPE);
               cell_in  = item_ff.seg_col;
               x0_in    = v_ff[2];
               x1_in    = v_ff[3];
               y0_in    = v_ff[4];
               y1_in    = v_ff[5];
               if (item_ff.seg_col == 9'(LAST_COL)) begin
                  status_in = ST_CLAMPED;
                  if (item_ff.req.command != CMD_SLOPE) begin
                     res_in   = v_ff[5];
                     state_in = B_OUT;
                  end
               end else if (item_ff.seg_col == peak_column) begin
                  if (tq < v_ff[0]) begin
                     x1_in = v_ff[0];
                     y1_in = v_ff[1];
                  end else if (tq > v_ff[0]) begin
                     x0_in = v_ff[0];
                     y0_in = v_ff[1];
                  end else begin
                     res_in   = (item_ff.req.command == CMD_SLOPE) ? 64'sd1 : v_ff[1];
                     state_in = B_OUT;
                  end
               end
            end
         end
         B_LOOP: begin
            rd_en   = 1'b1;
            rd_addr = addr_of(3'd1, g_ff[8:0]);
            state_in = (hi_ff > g_ff + 10'd1) ? B_CHECK : B_TAIL;
         end
         B_CHECK: begin
            if (pq == rd_value) begin
               rd_en    = 1'b1;
               rd_addr  = addr_of(3'd0, g_ff[8:0]);
               state_in = B_HIT;
            end else begin
               if (cond) begin
                  hi_in = g_ff;
                  g_in  = (g_ff + lo_ff) >> 1;
               end else begin
                  lo_in = g_ff;
                  g_in  = (hi_ff + g_ff) >> 1;
               end
               n_in = n_ff + NW'(1);
               if (n_in > NW'(SEARCH_LIMIT)) begin
                  res_in    = 64'sd0;
                  status_in = ST_NO_CONVERGE;
                  cell_in   = g_in[8:0];
                  state_in  = B_OUT;
               end else begin
                  state_in = B_LOOP;
               end
            end
         end
         B_HIT: begin
            res_in   = rd_value;
            cell_in  = g_ff[8:0];
            state_in = B_OUT;
         end
         B_TAIL: begin
            // step back one column when the last probe overshoots, stay inside the table
            if (cond && g_ff != 10'd0) cc_in = g_ff[8:0] - 9'd1;
            else if (cond)             cc_in = 9'd0;
            else                       cc_in = g_ff[8:0];
            if (cc_in > 9'(LAST_COL - 1)) cc_in = 9'(LAST_COL - 1);
            rr_in      = 3'd1;
            k_in       = 3'd2;
            bracket_in = 1'b1;
            state_in   = B_FETCH;
         end
         B_PREP: begin
            d_in     = sat_sub(x1_ff, x0_ff);
            na_in    = slope_ff ? sat_sub(y1_ff, y0_ff) : sat_sub(xq_ff, x0_ff);
            nb_in    = slope_ff ? Q_ONE : sat_sub(y1_ff, y0_ff);
            state_in = B_START;
         end
         B_START: begin
            if (d_ff == 64'sd0) begin
               res_in   = slope_ff ? 64'sd0 : y0_ff;
               state_in = B_OUT;
            end else begin
               md_req.start = 1'b1;
               state_in     = B_DIVIDE;
            end
         end
         B_DIVIDE: begin
            if (md_rsp.done) begin
               res_in   = slope_ff ? md_rsp.quotient : sat_add(y0_ff, md_rsp.quotient);
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_value = res_ff;
               rsp_in.cell_column  = cell_ff;
               rsp_in.status       = status_ff;
               state_in            = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= item_ff.req.data_value;
      if (rd_en)  rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_live_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_live_ff   <= rd_live;
      end
      rd_zero_ff <= rd_zero;
      rd_slot_ff <= rd_slot;
      if (rd_live_ff) v_ff[rd_slot_ff] <= rd_value;
      item_ff    <= item_in;
      k_ff       <= k_in;
      rr_ff      <= rr_in;
      cc_ff      <= cc_in;
      bracket_ff <= bracket_in;
      rising_ff  <= rising_in;
      slope_ff   <= slope_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
      g_ff       <= g_in;
      n_ff       <= n_in;
      x0_ff      <= x0_in;
      x1_ff      <= x1_in;
      y0_ff      <= y0_in;
      y1_ff      <= y1_in;
      xq_ff      <= xq_in;
      d_ff       <= d_in;
      na_ff      <= na_in;
      nb_ff      <= nb_in;
      res_ff     <= res_in;
      cell_ff    <= cell_in;
      status_ff  <= status_in;
      rsp_ff     <= rsp_in;
   end

   `STIC_ASSERT_NXT(a_div_launch, clock, reset, md_req.start, state_ff == B_DIVIDE)
   `STIC_ASSERT_IMP(a_check_follows_probe, clock, reset, state_ff == B_CHECK, $past(state_ff) == B_LOOP)
   `STIC_ASSERT_NXT(a_result_posted, clock, reset, state_ff == B_OUT && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == B_IDLE)
endmodule

// ----- src/segmented_table_interpolator_core.sv -----
// Top level of the segmented table interpolator.
//
// Requests enter on req_valid/req_ready, one transaction per item; each item
// gives exactly one transaction on rsp_valid/rsp_ready, in order. csr_valid
// with csr_data sets the peak column (values above 330 saturate to 330) and is
// always ready; write it only while the block is idle.
// A front stage registers each request and maps its temperature to a column,
// a two-entry queue decouples it from the back end, so new requests are taken
// while a result waits for the receiver. When rsp_ready is low the result
// holds and the back end waits in its output state with its next result.
// Load writes a table entry. Interpolate and slope read the table, then use
// the shared multiply/divide unit (4 partial products, 64 restoring steps).
// Inverse lookup adds a binary search, a table read and a compare per probe,
// bounded by SEARCH_LIMIT, and a bracket fetch of the neighbouring cells. The
// divider and the single table read port set the rate: one item at a time.
// Reset (synchronous) empties the queue and returns the peak column to 289;
// table contents are undefined until loaded.
`timescale 1ns / 1ps
module segmented_table_interpolator_core import stic_pkg::*; #(
   parameter int ROWS         = 8,
   parameter int SEARCH_LIMIT = 50
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_payload,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_payload,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [8:0] csr_data
);
   logic [8:0]       peak_ff, peak_in;
   logic             push, pop;
   entry_type        push_entry, pop_entry;
   queue_status_type q_status;

   assign csr_ready = 1'b1;

   always_comb begin
      peak_in = peak_ff;
      if (csr_valid) peak_in = (csr_data > 9'(LAST_COL)) ? 9'(LAST_COL) : csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) peak_ff <= PEAK_RESET;
      else       peak_ff <= peak_in;
   end

   stic_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push        (push),
      .push_entry  (push_entry),
      .q_status    (q_status)
   );

   stic_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   stic_back #(
      .ROWS         (ROWS),
      .SEARCH_LIMIT (SEARCH_LIMIT)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .peak_column (peak_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );
endmodule
